>>> rtl/ogbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ogbd_pkg;

  localparam int CELL_W    = 8;
  localparam int THR_W     = 5;
  localparam int GRID_W    = 10;
  localparam int COORD_W   = 7;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 10;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_OCC_THR   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_THR = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 8'd3;

  localparam logic signed [CELL_W-1:0] OCC_THR_RST   = 8'sd1;
  localparam logic [THR_W-1:0]         BLOCK_THR_RST = 5'd8;
  localparam logic [GRID_W-1:0]        GRID_SIDE_RST = 10'd400;

  typedef struct packed {
    logic               occ;
    logic               first;
    logic               last;
    logic               frame_end;
    logic [COORD_W-1:0] block_y;
  } ogbd_tag_t;

endpackage

`default_nettype wire

>>> rtl/occupancy_grid_block_downsampler.sv
// Channel  | Ports                               | Contents
// in_      | in_tvalid/in_tready/in_tdata/in_tuser | one grid cell per transfer
// out_     | out_tvalid/out_tready/out_tdata/out_tuser/out_tlast | one finished block
// cfg_     | cfg_valid/cfg_ready/cfg_index/cfg_data | register write
//
// Sustains one cell per cycle. A transfer walks the chain of block-column cells, one
// stage per cycle while the chain is not held, and the block's result is registered
// after the last cell of the chain.
// Synchronous active-low reset clears position, all block-column counts and the
// registers to their defaults. While a result waits untaken the whole chain holds
// and in_tready is low; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module occupancy_grid_block_downsampler #(
  parameter int MAX_GRID_SIDE = 512,
  parameter int BLOCK_SIDE    = 4
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [ogbd_pkg::IN_DATA_W-1:0]       in_tdata,   // [7:0] cell_value
  input  wire logic                                 in_tuser,   // [0] frame_start
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [ogbd_pkg::OUT_DATA_W-1:0]           out_tdata,  // [6:0] block_x, [13:7] block_y
  output logic                                      out_tuser,  // [0] blocked
  output logic                                      out_tlast,  // frame_end
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [ogbd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ogbd_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import ogbd_pkg::*;

  localparam int NC  = MAX_GRID_SIDE / BLOCK_SIDE;
  localparam int BW  = (NC > 1) ? $clog2(NC) : 1;
  localparam int PW  = $clog2(MAX_GRID_SIDE);
  localparam int SW  = PW + 1;
  localparam int LW  = (SW > GRID_W) ? SW : GRID_W;
  localparam int CW  = $clog2(BLOCK_SIDE * BLOCK_SIDE + 1);
  localparam int TW  = (CW > THR_W) ? CW : THR_W;

  logic signed [CELL_W-1:0] occ_thr_r;
  logic [THR_W-1:0]         blk_thr_r;
  logic [GRID_W-1:0]        cols_r;
  logic [GRID_W-1:0]        rows_r;

  logic [LW-1:0] cols_clip, rows_clip, cols_rnd, rows_rnd;
  logic [SW-1:0] cols_use, rows_use;

  logic                adv;
  logic                take;
  logic [BW-1:0]       front_bcol;
  ogbd_tag_t           front_tag;

  logic                ch_vld  [0:NC];
  logic [BW-1:0]       ch_bcol [0:NC];
  ogbd_tag_t           ch_tag  [0:NC];
  logic [CW-1:0]       ch_cnt  [0:NC];

  logic                out_valid_r;
  logic [COORD_W-1:0]  bx_r, by_r;
  logic                blocked_r, fend_r;
  logic [BW+COORD_W-1:0] bx_ext;

  always_comb begin
    cols_clip = (LW'(cols_r) > LW'(MAX_GRID_SIDE)) ? LW'(MAX_GRID_SIDE) : LW'(cols_r);
    rows_clip = (LW'(rows_r) > LW'(MAX_GRID_SIDE)) ? LW'(MAX_GRID_SIDE) : LW'(rows_r);
    cols_rnd  = cols_clip - LW'(cols_clip % BLOCK_SIDE);
    rows_rnd  = rows_clip - LW'(rows_clip % BLOCK_SIDE);
    if (cols_rnd < LW'(BLOCK_SIDE)) begin
      cols_rnd = LW'(BLOCK_SIDE);
    end
    if (rows_rnd < LW'(BLOCK_SIDE)) begin
      rows_rnd = LW'(BLOCK_SIDE);
    end
    cols_use = cols_rnd[SW-1:0];
    rows_use = rows_rnd[SW-1:0];
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_thr_r <= OCC_THR_RST;
      blk_thr_r <= BLOCK_THR_RST;
      cols_r    <= GRID_SIDE_RST;
      rows_r    <= GRID_SIDE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OCC_THR:   occ_thr_r <= cfg_data[CELL_W-1:0];
        REG_BLOCK_THR: blk_thr_r <= cfg_data[THR_W-1:0];
        REG_GRID_COLS: cols_r    <= cfg_data[GRID_W-1:0];
        REG_GRID_ROWS: rows_r    <= cfg_data[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign take      = in_tvalid && adv;

  ogbd_front #(
    .BLOCK_SIDE    (BLOCK_SIDE),
    .PW            (PW),
    .SW            (SW),
    .BW            (BW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .cell_value  (in_tdata[CELL_W-1:0]),
    .frame_start (in_tuser),
    .occ_thr     (occ_thr_r),
    .cols        (cols_use),
    .rows        (rows_use),
    .bcol        (front_bcol),
    .tag         (front_tag)
  );

  assign ch_vld[0]  = in_tvalid;
  assign ch_bcol[0] = front_bcol;
  assign ch_tag[0]  = front_tag;
  assign ch_cnt[0]  = '0;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    ogbd_cell #(
      .BW  (BW),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (ch_vld[i]),
      .in_bcol  (ch_bcol[i]),
      .in_tag   (ch_tag[i]),
      .in_cnt   (ch_cnt[i]),
      .out_vld  (ch_vld[i+1]),
      .out_bcol (ch_bcol[i+1]),
      .out_tag  (ch_tag[i+1]),
      .out_cnt  (ch_cnt[i+1])
    );
  end

  assign bx_ext = {{COORD_W{1'b0}}, ch_bcol[NC]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ch_vld[NC] && ch_tag[NC].last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bx_r      <= bx_ext[COORD_W-1:0];
      by_r      <= ch_tag[NC].block_y;
      blocked_r <= (TW'(ch_cnt[NC]) >= TW'(blk_thr_r));
      fend_r    <= ch_tag[NC].frame_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 2 * COORD_W){1'b0}}, by_r, bx_r};
  assign out_tuser  = blocked_r;
  assign out_tlast  = fend_r;

endmodule

`default_nettype wire

>>> rtl/ogbd_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ogbd_cell #(
  parameter int BW  = 7,
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic                 in_vld,
  input  wire logic [BW-1:0]        in_bcol,
  input  wire ogbd_pkg::ogbd_tag_t  in_tag,
  input  wire logic [CW-1:0]        in_cnt,
  output logic                      out_vld,
  output logic [BW-1:0]             out_bcol,
  output ogbd_pkg::ogbd_tag_t       out_tag,
  output logic [CW-1:0]             out_cnt
);
  import ogbd_pkg::*;

  logic            vld_r;
  logic [BW-1:0]   bcol_r;
  ogbd_tag_t       tag_r;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;
  logic [CW-1:0]   pass_r;
  logic [CW-1:0]   pass_nxt;
  logic            hit;

  assign hit      = in_vld && (in_bcol == BW'(IDX));
  assign cnt_nxt  = in_tag.first ? CW'(in_tag.occ) : cnt_r + CW'(in_tag.occ);
  assign pass_nxt = hit ? cnt_nxt : in_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      cnt_r <= '0;
    end else if (adv) begin
      vld_r <= in_vld;
      if (hit) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bcol_r <= in_bcol;
      tag_r  <= in_tag;
      pass_r <= pass_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_bcol = bcol_r;
  assign out_tag  = tag_r;
  assign out_cnt  = pass_r;

endmodule

`default_nettype wire

>>> rtl/ogbd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ogbd_front #(
  parameter int BLOCK_SIDE    = 4,
  parameter int PW            = 9,
  parameter int SW            = 10,
  parameter int BW            = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          take,
  input  wire logic signed [ogbd_pkg::CELL_W-1:0] cell_value,
  input  wire logic                          frame_start,
  input  wire logic signed [ogbd_pkg::CELL_W-1:0] occ_thr,
  input  wire logic [SW-1:0]                 cols,
  input  wire logic [SW-1:0]                 rows,
  output logic [BW-1:0]                      bcol,
  output ogbd_pkg::ogbd_tag_t                tag
);
  import ogbd_pkg::*;

  logic [PW-1:0] col_r, col_nxt;
  logic [PW-1:0] row_r, row_nxt;
  logic [SW-1:0] c0, r0, c1, r1, r2, cn, rn;
  logic [SW-1:0] by_full;
  logic [SW+COORD_W-1:0] by_ext;

  always_comb begin
    c0 = frame_start ? '0 : SW'(col_r);
    r0 = frame_start ? '0 : SW'(row_r);
    if (c0 >= cols) begin
      c1 = '0;
      r1 = r0 + SW'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2 = (r1 >= rows) ? '0 : r1;

    cn = c1 + SW'(1);
    rn = r2;
    if (cn >= cols) begin
      cn = '0;
      rn = r2 + SW'(1);
      if (rn >= rows) begin
        rn = '0;
      end
    end
    col_nxt = cn[PW-1:0];
    row_nxt = rn[PW-1:0];
  end

  assign bcol    = BW'(c1 / BLOCK_SIDE);
  assign by_full = SW'(r2 / BLOCK_SIDE);
  assign by_ext  = {{COORD_W{1'b0}}, by_full};

  assign tag.occ       = (cell_value > occ_thr);
  assign tag.first     = ((c1 % BLOCK_SIDE) == 0) && ((r2 % BLOCK_SIDE) == 0);
  assign tag.last      = ((c1 % BLOCK_SIDE) == (BLOCK_SIDE - 1)) &&
                         ((r2 % BLOCK_SIDE) == (BLOCK_SIDE - 1));
  assign tag.frame_end = (c1 == cols - SW'(1)) && (r2 == rows - SW'(1));
  assign tag.block_y   = by_ext[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (take) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ogbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ogbd_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [ogbd_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                           out_tuser,
  input wire logic                           out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");

endmodule

bind occupancy_grid_block_downsampler ogbd_checker u_ogbd_checker (.*);

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ogbd_pkg::*;

  localparam int SIDE          = 4;
  localparam int MAX_SIDE      = 512;
  localparam int BLOCK_COLS    = MAX_SIDE / SIDE + 1;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 600;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_CELLS  = 450;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = 8'hFF;

  typedef enum logic [1:0] {CELL_ITEM, REG_WRITE, SETTLE, HOLD_OUTPUT} stim_kind_t;

  typedef struct {
    stim_kind_t           kind;
    logic [CELL_W-1:0]    cell_val;
    logic                 start;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
    int                   gap;
  } stim_t;

  typedef struct packed {
    logic [COORD_W-1:0] block_x;
    logic [COORD_W-1:0] block_y;
    logic               blocked;
    logic               frame_end;
  } block_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  logic                  in_tuser  = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DAT_W-1:0]  cfg_data  = '0;

  occupancy_grid_block_downsampler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  stim_t  stim_q[$];
  block_t pending_blocks[$];

  logic signed [CELL_W-1:0] thr_occ   = OCC_THR_RST;
  logic [THR_W-1:0]         thr_block = BLOCK_THR_RST;
  logic [GRID_W-1:0]        cols_reg  = GRID_SIDE_RST;
  logic [GRID_W-1:0]        rows_reg  = GRID_SIDE_RST;
  int unsigned              col_pos;
  int unsigned              row_pos;
  int unsigned              col_count[BLOCK_COLS];

  logic signed [CELL_W-1:0] plan_occ  = OCC_THR_RST;
  logic [GRID_W-1:0]        plan_cols = GRID_SIDE_RST;
  logic [GRID_W-1:0]        plan_rows = GRID_SIDE_RST;

  logic hold_req = 1'b0;
  int   gap_left, settle_left, hold_left, stall_left, quiet;
  bit   gap_armed, hold_taken, rx_calm;
  int   errors, cells_moved, regs_written, results_seen, blocked_seen, frame_ends_seen;

  function automatic int unsigned usable_side(input logic [GRID_W-1:0] r);
    int unsigned s;
    s = r;
    if (s > MAX_SIDE) s = MAX_SIDE;
    s -= s % SIDE;
    if (s < SIDE) s = SIDE;
    return s;
  endfunction

  function automatic void load_register(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DAT_W-1:0] d);
    case (idx)
      REG_OCC_THR:   thr_occ   = d[CELL_W-1:0];
      REG_BLOCK_THR: thr_block = d[THR_W-1:0];
      REG_GRID_COLS: cols_reg  = d;
      REG_GRID_ROWS: rows_reg  = d;
      default: ;
    endcase
  endfunction

  function automatic bit pool_cell(input logic [CELL_W-1:0] raw, input logic start,
                                   output block_t res);
    int unsigned cols, rows, bcol, cnt;
    logic [31:0] bx, by;
    logic occ;
    cols = usable_side(cols_reg);
    rows = usable_side(rows_reg);
    occ  = $signed(raw) > thr_occ;
    res  = '0;
    if (start) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= rows) row_pos = 0;
    bcol = col_pos / SIDE;
    if (bcol >= BLOCK_COLS) bcol = BLOCK_COLS - 1;
    if (col_pos % SIDE == 0 && row_pos % SIDE == 0) cnt = occ;
    else cnt = col_count[bcol] + occ;
    col_count[bcol] = cnt;
    pool_cell = 1'b0;
    if (col_pos % SIDE == SIDE - 1 && row_pos % SIDE == SIDE - 1) begin
      bx = bcol;
      by = row_pos / SIDE;
      res.block_x   = bx[COORD_W-1:0];
      res.block_y   = by[COORD_W-1:0];
      res.blocked   = cnt >= thr_block;
      res.frame_end = (col_pos == cols - 1) && (row_pos == rows - 1);
      pool_cell = 1'b1;
    end
    col_pos++;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= rows) row_pos = 0;
    end
  endfunction

  task automatic add_cell(input logic [CELL_W-1:0] v, input logic s, input int g);
    stim_t it;
    it = '{kind: CELL_ITEM, cell_val: v, start: s, idx: '0, data: '0, gap: g};
    stim_q.insert(stim_q.size(), it);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
    stim_t it;
    it = '{kind: REG_WRITE, cell_val: '0, start: 1'b0, idx: idx, data: d,
           gap: $urandom_range(0, 10)};
    stim_q.insert(stim_q.size(), it);
    case (idx)
      REG_OCC_THR:   plan_occ  = d[CELL_W-1:0];
      REG_GRID_COLS: plan_cols = d;
      REG_GRID_ROWS: plan_rows = d;
      default: ;
    endcase
  endtask

  task automatic add_marker(input stim_kind_t k);
    stim_t it;
    it = '{kind: k, cell_val: '0, start: 1'b0, idx: '0, data: '0, gap: 0};
    stim_q.insert(stim_q.size(), it);
  endtask

  // frame starts fall on frame boundaries when lead is set; noise only when not calm
  task automatic add_frames(input int count, input bit calm, input bit lead);
    int frame_len, k, t;
    logic [CELL_W-1:0] v;
    logic s;
    frame_len = usable_side(plan_cols) * usable_side(plan_rows);
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 3))
        0: v = 8'($urandom_range(0, 255));
        1: begin
          t = int'(plan_occ) + int'($urandom_range(0, 2)) - 1;
          v = t[CELL_W-1:0];
        end
        2: v = 8'($urandom_range(0, 100));
        default: v = $urandom_range(0, 1) ? 8'hFF : 8'h7F;
      endcase
      s = lead && (k % frame_len == 0) && (k == 0 || $urandom_range(0, 1) == 1);
      if (!calm && $urandom_range(0, 63) == 0) s = 1'b1;
      add_cell(v, s, calm ? 0 : $urandom_range(0, 10));
    end
  endtask

  function automatic logic [CFG_DAT_W-1:0] pick_side();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return 10'($urandom_range(0, 17));
    if (r < 19) return 10'($urandom_range(4, 32));
    case ($urandom_range(0, 2))
      0: return 10'd512;
      1: return 10'd513;
      default: return 10'h3FF;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin : sender
    stim_t  head;
    block_t res;
    logic   nx_in_valid, nx_cfg_valid;
    int     k;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      cfg_valid <= 1'b0;
      cfg_index <= '0;
      cfg_data  <= '0;
      hold_req  <= 1'b0;
      thr_occ   = OCC_THR_RST;
      thr_block = BLOCK_THR_RST;
      cols_reg  = GRID_SIDE_RST;
      rows_reg  = GRID_SIDE_RST;
      col_pos   = 0;
      row_pos   = 0;
      for (k = 0; k < BLOCK_COLS; k++) col_count[k] = 0;
      gap_left    = 0;
      gap_armed   = 1'b0;
      settle_left = SETTLE_CYCLES;
    end else begin
      nx_in_valid  = in_tvalid;
      nx_cfg_valid = cfg_valid;
      if (in_tvalid && in_tready) begin
        if (pool_cell(in_tdata[CELL_W-1:0], in_tuser, res))
          pending_blocks.insert(pending_blocks.size(), res);
        cells_moved++;
        nx_in_valid = 1'b0;
        settle_left = SETTLE_CYCLES;
      end
      if (cfg_valid && cfg_ready) begin
        load_register(cfg_index, cfg_data);
        regs_written++;
        nx_cfg_valid = 1'b0;
      end
      if (!nx_in_valid && !nx_cfg_valid && stim_q.size() != 0) begin
        head = stim_q[0];
        case (head.kind)
          SETTLE: begin
            if (pending_blocks.size() != 0) settle_left = SETTLE_CYCLES;
            else if (settle_left != 0) settle_left--;
            else begin
              stim_q.delete(0);
              settle_left = SETTLE_CYCLES;
            end
          end
          HOLD_OUTPUT: begin
            hold_req <= 1'b1;
            stim_q.delete(0);
          end
          default: begin
            if (!gap_armed) begin
              gap_left  = head.gap;
              gap_armed = 1'b1;
            end
            if (gap_left != 0) gap_left--;
            else begin
              stim_q.delete(0);
              gap_armed = 1'b0;
              if (head.kind == CELL_ITEM) begin
                nx_in_valid = 1'b1;
                in_tdata <= head.cell_val;
                in_tuser <= head.start;
              end else begin
                nx_cfg_valid = 1'b1;
                cfg_index <= head.idx;
                cfg_data  <= head.data;
              end
            end
          end
        endcase
      end
      in_tvalid <= nx_in_valid;
      cfg_valid <= nx_cfg_valid;
    end
  end

  always @(posedge clk) begin : receiver
    block_t want;
    logic   nx_ready;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      rx_calm    = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (out_tuser) blocked_seen++;
        if (out_tlast) frame_ends_seen++;
        if (pending_blocks.size() == 0) begin
          $error("unexpected block result x=%0d y=%0d", out_tdata[COORD_W-1:0],
                 out_tdata[2*COORD_W-1:COORD_W]);
          errors++;
        end else begin
          want = pending_blocks[0];
          pending_blocks.delete(0);
          if (out_tdata[COORD_W-1:0] !== want.block_x) begin
            $error("block_x: expected %0d, got %0d", want.block_x, out_tdata[COORD_W-1:0]);
            errors++;
          end
          if (out_tdata[2*COORD_W-1:COORD_W] !== want.block_y) begin
            $error("block_y: expected %0d, got %0d", want.block_y,
                   out_tdata[2*COORD_W-1:COORD_W]);
            errors++;
          end
          if (out_tuser !== want.blocked) begin
            $error("blocked: expected %0d, got %0d", want.blocked, out_tuser);
            errors++;
          end
          if (out_tlast !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, out_tlast);
            errors++;
          end
        end
        if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
        stall_left = rx_calm ? 0 : $urandom_range(0, 10);
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        nx_ready = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        nx_ready = 1'b0;
      end else begin
        nx_ready = 1'b1;
      end
      out_tready <= nx_ready;
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    logic [CELL_W-1:0] dir_cells [16];
    int p, n, k, random_cells;
    dir_cells = '{8'h02, 8'h01, 8'h7F, 8'h80, 8'h64, 8'h00, 8'hFF, 8'h02,
                  8'h03, 8'h32, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02};

    // default thresholds on a single 4x4 frame
    add_marker(SETTLE);
    add_write(REG_GRID_COLS, 10'd4);
    add_write(REG_GRID_ROWS, 10'd4);
    for (k = 0; k < 16; k++) add_cell(dir_cells[k], k == 0, $urandom_range(0, 10));
    add_marker(SETTLE);
    add_write(REG_OCC_THR, 10'h380);
    add_write(REG_BLOCK_THR, 10'h3E0);
    add_write(REG_UNUSED_LOW, 10'h3FF);
    add_write(REG_UNUSED_HIGH, 10'h000);
    add_cell(8'h80, 1'b0, 0);
    add_cell(8'h7F, 1'b0, 0);
    add_cell(8'h81, 1'b1, 0);
    add_cell(8'hFF, 1'b0, 3);
    add_cell(8'h00, 1'b0, 0);
    add_cell(8'h01, 1'b0, 10);

    random_cells = 0;
    p = 0;
    while (random_cells < RANDOM_CELLS) begin
      add_marker(SETTLE);
      case (p)
        0: begin
          add_write(REG_GRID_COLS, 10'd5);
          add_write(REG_GRID_ROWS, 10'd6);
        end
        1: begin
          add_write(REG_OCC_THR, 10'h07F);
          add_write(REG_BLOCK_THR, 10'h01F);
        end
        2: begin
          // walk a narrow grid to row 3, then widen to the largest column count
          add_write(REG_GRID_COLS, 10'd4);
          add_write(REG_GRID_ROWS, 10'h3FF);
          add_frames(12, 1'b1, 1'b1);
          add_marker(SETTLE);
          add_write(REG_GRID_COLS, 10'h3FF);
          add_frames(128, 1'b1, 1'b0);
          random_cells += 140;
        end
        3: begin
          add_write(REG_OCC_THR, 10'h2FF);
          add_write(REG_BLOCK_THR, 10'd16);
          add_write(REG_GRID_COLS, 10'd8);
          add_write(REG_GRID_ROWS, 10'd4);
        end
        4: begin
          // hold the output while cells keep streaming in
          add_write(REG_GRID_COLS, 10'd4);
          add_write(REG_GRID_ROWS, 10'd4);
          add_marker(HOLD_OUTPUT);
          add_frames(80, 1'b0, 1'b1);
          random_cells += 80;
        end
        default: begin
          if ($urandom_range(0, 1))
            case ($urandom_range(0, 5))
              0: add_write(REG_OCC_THR, {2'($urandom), 8'h80});
              1: add_write(REG_OCC_THR, {2'($urandom), 8'h7F});
              2: add_write(REG_OCC_THR, {2'($urandom), 8'hFF});
              3: add_write(REG_OCC_THR, {2'($urandom), 8'h00});
              4: add_write(REG_OCC_THR, {2'($urandom), 8'h01});
              default: add_write(REG_OCC_THR, 10'($urandom));
            endcase
          if ($urandom_range(0, 1))
            case ($urandom_range(0, 3))
              0: add_write(REG_BLOCK_THR, {5'($urandom), 5'd0});
              1: add_write(REG_BLOCK_THR, {5'($urandom), 5'd16});
              2: add_write(REG_BLOCK_THR, {5'($urandom), 5'd31});
              default: add_write(REG_BLOCK_THR, 10'($urandom));
            endcase
          if ($urandom_range(0, 1)) add_write(REG_GRID_COLS, pick_side());
          if ($urandom_range(0, 1)) add_write(REG_GRID_ROWS, pick_side());
          if ($urandom_range(0, 7) == 0)
            add_write(8'($urandom_range(REG_UNUSED_LOW, REG_UNUSED_HIGH)), 10'($urandom));
        end
      endcase
      if (p != 2 && p != 4) begin
        n = $urandom_range(24, 96);
        add_frames(n, $urandom_range(0, 3) == 0, $urandom_range(0, 3) != 0);
        random_cells += n;
      end
      p++;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_tvalid || cfg_valid) @(posedge clk);
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("streamed %0d cells and %0d register writes over %0d setting phases",
             cells_moved, regs_written, p);
    $display("checked %0d finished blocks, %0d blocked, %0d closing a frame",
             results_seen, blocked_seen, frame_ends_seen);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
